// File: hw/rtl/bcvg_pkg.sv
// ----------------------------------------------------------------------------
// bcvg_pkg
// Shared types, register indexes and the vertex table for the box cell
// vertex generator.
// ----------------------------------------------------------------------------
package bcvg_pkg;

  localparam int unsigned DefMaxDivisions = 1024;
  localparam int unsigned DefFracBits     = 16;

  localparam int unsigned SizeW   = 31;
  localparam int unsigned DivW    = 11;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 32;

  localparam int unsigned VertsPerCell = 36;
  localparam int unsigned VertsPerFace = 6;
  localparam int unsigned NumFaces     = 6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSizeX     = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgSizeY     = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgSizeZ     = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgDivisions = 8'd3;

  // per-axis coordinate selector
  typedef enum logic [1:0] {
    CoordLo  = 2'd0,
    CoordHi  = 2'd1,
    CoordPos = 2'd2,
    CoordNeg = 2'd3
  } coord_sel_e;

  typedef struct packed {
    logic [IdxW-1:0] cell_row;
    logic [IdxW-1:0] cell_col;
  } cell_t;

  typedef struct packed {
    logic signed [CoordW-1:0] vert_x;
    logic signed [CoordW-1:0] vert_y;
    logic signed [CoordW-1:0] vert_z;
    logic [2:0]               face_id;
    logic                     bad_cell;
    logic                     last;
  } vert_t;

  typedef struct packed {
    coord_sel_e cz;
    coord_sel_e cy;
    coord_sel_e cx;
  } vcode_t;

  function automatic vcode_t vert_code(input logic [5:0] k);
    vcode_t c;
    c = '{cz: CoordNeg, cy: CoordNeg, cx: CoordNeg};
    case (k)
      // front
      6'd0:  c = '{cz: CoordPos, cy: CoordLo,  cx: CoordLo};
      6'd1:  c = '{cz: CoordPos, cy: CoordLo,  cx: CoordHi};
      6'd2:  c = '{cz: CoordPos, cy: CoordHi,  cx: CoordLo};
      6'd3:  c = '{cz: CoordPos, cy: CoordHi,  cx: CoordLo};
      6'd4:  c = '{cz: CoordPos, cy: CoordLo,  cx: CoordHi};
      6'd5:  c = '{cz: CoordPos, cy: CoordHi,  cx: CoordHi};
      // back
      6'd6:  c = '{cz: CoordNeg, cy: CoordLo,  cx: CoordLo};
      6'd7:  c = '{cz: CoordNeg, cy: CoordHi,  cx: CoordLo};
      6'd8:  c = '{cz: CoordNeg, cy: CoordLo,  cx: CoordHi};
      6'd9:  c = '{cz: CoordNeg, cy: CoordHi,  cx: CoordLo};
      6'd10: c = '{cz: CoordNeg, cy: CoordHi,  cx: CoordHi};
      6'd11: c = '{cz: CoordNeg, cy: CoordLo,  cx: CoordHi};
      // right
      6'd12: c = '{cz: CoordLo,  cy: CoordLo,  cx: CoordPos};
      6'd13: c = '{cz: CoordLo,  cy: CoordHi,  cx: CoordPos};
      6'd14: c = '{cz: CoordHi,  cy: CoordLo,  cx: CoordPos};
      6'd15: c = '{cz: CoordLo,  cy: CoordHi,  cx: CoordPos};
      6'd16: c = '{cz: CoordHi,  cy: CoordHi,  cx: CoordPos};
      6'd17: c = '{cz: CoordHi,  cy: CoordLo,  cx: CoordPos};
      // left
      6'd18: c = '{cz: CoordLo,  cy: CoordLo,  cx: CoordNeg};
      6'd19: c = '{cz: CoordHi,  cy: CoordLo,  cx: CoordNeg};
      6'd20: c = '{cz: CoordLo,  cy: CoordHi,  cx: CoordNeg};
      6'd21: c = '{cz: CoordLo,  cy: CoordHi,  cx: CoordNeg};
      6'd22: c = '{cz: CoordHi,  cy: CoordLo,  cx: CoordNeg};
      6'd23: c = '{cz: CoordHi,  cy: CoordHi,  cx: CoordNeg};
      // top
      6'd24: c = '{cz: CoordLo,  cy: CoordPos, cx: CoordLo};
      6'd25: c = '{cz: CoordHi,  cy: CoordPos, cx: CoordLo};
      6'd26: c = '{cz: CoordLo,  cy: CoordPos, cx: CoordHi};
      6'd27: c = '{cz: CoordHi,  cy: CoordPos, cx: CoordLo};
      6'd28: c = '{cz: CoordHi,  cy: CoordPos, cx: CoordHi};
      6'd29: c = '{cz: CoordLo,  cy: CoordPos, cx: CoordHi};
      // bottom
      6'd30: c = '{cz: CoordLo,  cy: CoordNeg, cx: CoordLo};
      6'd31: c = '{cz: CoordLo,  cy: CoordNeg, cx: CoordHi};
      6'd32: c = '{cz: CoordHi,  cy: CoordNeg, cx: CoordLo};
      6'd33: c = '{cz: CoordHi,  cy: CoordNeg, cx: CoordLo};
      6'd34: c = '{cz: CoordLo,  cy: CoordNeg, cx: CoordHi};
      6'd35: c = '{cz: CoordHi,  cy: CoordNeg, cx: CoordHi};
      default: c = '{cz: CoordNeg, cy: CoordNeg, cx: CoordNeg};
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/box_cell_vertex_generator.sv
// ----------------------------------------------------------------------------
// box_cell_vertex_generator
// Emits the 36 triangle vertices of one grid cell of a subdivided box.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: a cell (row, column) transfers on a rising edge with
//   start high and busy low. A one-entry holding register takes it, so the
//   next cell may be offered while the current one is still being emitted;
//   busy drops in the cycle the holding register hands its cell on.
//   Result channel: vert_valid_o strobes one vertex per cycle; each vertex
//   is on vert_o for exactly one cycle. The receiver cannot stall.
//   Configuration channel: cfg_ready_o is always high. A write to a size or
//   to divisions restarts a bit-serial divider that loads the sizes and then
//   forms the three steps one quotient bit at a time; busy stays high
//   meanwhile. Unknown indexes are ignored.
//   Path: a cell passes the holding register, the sequencer, the vertex code
//   stage, the product stage and the coordinate stage to the output register.
//   Output: a good cell yields all its vertices, a bad cell a single one; the
//   vertex sequencer issues one vertex a cycle, and back-to-back cells run
//   without gaps.
//   Reset: sizes return to 1.0, divisions to 1, the steps are loaded
//   directly, no result is pending.
// ----------------------------------------------------------------------------
module box_cell_vertex_generator
  import bcvg_pkg::*;
#(
  parameter int unsigned MAX_DIVISIONS = bcvg_pkg::DefMaxDivisions,
  parameter int unsigned FRAC_BITS     = bcvg_pkg::DefFracBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  bcvg_pkg::cell_t                 cell_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bcvg_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bcvg_pkg::CfgDatW-1:0]    cfg_data_i,
  output logic                            vert_valid_o,
  output bcvg_pkg::vert_t                 vert_o
);

  localparam int unsigned MaxW = $clog2(MAX_DIVISIONS + 1) + 1;
  localparam logic [SizeW-1:0] SizeReset = SizeW'(64'd1 << FRAC_BITS);
  localparam logic [4:0] DivLastCnt = 5'(SizeW - 1);
  localparam logic [5:0] LastVert = 6'(VertsPerCell - 1);
  localparam logic [2:0] LastInFace = 3'(VertsPerFace - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SizeW-1:0] size_q [3];
  logic [DivW-1:0]  div_q;
  logic             cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[0] <= SizeReset;
      size_q[1] <= SizeReset;
      size_q[2] <= SizeReset;
      div_q     <= DivW'(1);
    end else if (cfg_fire) begin
      case (cfg_index_i)
        CfgSizeX:     size_q[0] <= cfg_data_i[SizeW-1:0];
        CfgSizeY:     size_q[1] <= cfg_data_i[SizeW-1:0];
        CfgSizeZ:     size_q[2] <= cfg_data_i[SizeW-1:0];
        CfgDivisions: div_q     <= cfg_data_i[DivW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Step divider: three restoring dividers sharing one bit counter. The
  // quotient shifts into the dividend register, which then holds the step.
  // --------------------------------------------------------------------------
  logic             div_kick_q;
  logic             div_busy_q;
  logic [4:0]       div_cnt_q;
  logic [SizeW-1:0] num_q [3];
  logic [DivW-1:0]  rem_q [3];
  logic [SizeW-1:0] num_d [3];
  logic [DivW-1:0]  rem_d [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [DivW:0] t;
      logic          ge;
      t  = {rem_q[a], num_q[a][SizeW-1]};
      ge = t >= {1'b0, div_q};
      rem_d[a] = ge ? DivW'(t - {1'b0, div_q}) : t[DivW-1:0];
      num_d[a] = {num_q[a][SizeW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_kick_q <= 1'b0;
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
      // reset sizes over one division: the step is the size itself
      for (int a = 0; a < 3; a++) begin
        num_q[a] <= SizeReset;
        rem_q[a] <= '0;
      end
    end else begin
      div_kick_q <= cfg_fire && (cfg_index_i == CfgSizeX || cfg_index_i == CfgSizeY ||
                                 cfg_index_i == CfgSizeZ || cfg_index_i == CfgDivisions);
      if (div_kick_q) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= '0;
        for (int a = 0; a < 3; a++) begin
          num_q[a] <= size_q[a];
          rem_q[a] <= '0;
        end
      end else if (div_busy_q) begin
        for (int a = 0; a < 3; a++) begin
          num_q[a] <= num_d[a];
          rem_q[a] <= rem_d[a];
        end
        div_cnt_q <= div_cnt_q + 5'd1;
        if (div_cnt_q == DivLastCnt) begin
          div_busy_q <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Holding register for the next cell
  // --------------------------------------------------------------------------
  logic  hold_valid_q;
  cell_t hold_q;
  logic  cmd_fire;
  logic  seq_take;

  // the holding register frees up in the cycle the sequencer takes its cell
  assign busy     = (hold_valid_q && !seq_take) || div_busy_q || div_kick_q;
  assign cmd_fire = start && !busy;

  // --------------------------------------------------------------------------
  // Vertex sequencer: one vertex a cycle, face and in-face counters kept
  // alongside the vertex number.
  // --------------------------------------------------------------------------
  logic            seq_active_q;
  logic            seq_bad_q;
  logic [5:0]      seq_k_q;
  logic [2:0]      seq_face_q;
  logic [2:0]      seq_fv_q;
  cell_t           seq_cell_q;
  logic            seq_last;
  logic            hold_bad;

  assign seq_last = seq_bad_q || (seq_k_q == LastVert);
  assign seq_take = hold_valid_q && (!seq_active_q || seq_last);
  assign hold_bad = (div_q == '0) || (MaxW'(div_q) > MaxW'(MAX_DIVISIONS)) ||
                    ({1'b0, hold_q.cell_row} >= div_q) ||
                    ({1'b0, hold_q.cell_col} >= div_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      seq_active_q <= 1'b0;
    end else begin
      if (cmd_fire) begin
        hold_valid_q <= 1'b1;
      end else if (seq_take) begin
        hold_valid_q <= 1'b0;
      end
      if (seq_take) begin
        seq_active_q <= 1'b1;
      end else if (seq_active_q && seq_last) begin
        seq_active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      hold_q <= cell_i;
    end
    if (seq_take) begin
      seq_cell_q <= hold_q;
      seq_bad_q  <= hold_bad;
      seq_k_q    <= '0;
      seq_face_q <= '0;
      seq_fv_q   <= '0;
    end else if (seq_active_q) begin
      seq_k_q <= seq_k_q + 6'd1;
      if (seq_fv_q == LastInFace) begin
        seq_fv_q   <= '0;
        seq_face_q <= seq_face_q + 3'd1;
      end else begin
        seq_fv_q <= seq_fv_q + 3'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: register vertex code and cell indexes
  // --------------------------------------------------------------------------
  logic            s1_valid_q;
  logic            s1_bad_q;
  logic            s1_last_q;
  logic [2:0]      s1_face_q;
  vcode_t          s1_code_q;
  logic [IdxW-1:0] s1_xi_q, s1_yi_q, s1_zi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= seq_active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_bad_q  <= seq_bad_q;
    s1_last_q <= seq_last;
    s1_face_q <= seq_face_q;
    s1_code_q <= vert_code(seq_k_q);
    s1_xi_q   <= seq_cell_q.cell_col;
    s1_yi_q   <= seq_cell_q.cell_row;
    // z follows the row on top and bottom, the column elsewhere
    s1_zi_q   <= (seq_face_q >= 3'd4) ? seq_cell_q.cell_row : seq_cell_q.cell_col;
  end

  // --------------------------------------------------------------------------
  // Stage 2: index times step per axis
  // --------------------------------------------------------------------------
  logic        s2_valid_q;
  logic        s2_bad_q;
  logic        s2_last_q;
  logic [2:0]  s2_face_q;
  vcode_t      s2_code_q;
  logic [CoordW-1:0] s2_prod_q [3];
  logic [IdxW-1:0]   s1_idx [3];

  assign s1_idx[0] = s1_xi_q;
  assign s1_idx[1] = s1_yi_q;
  assign s1_idx[2] = s1_zi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_bad_q  <= s1_bad_q;
    s2_last_q <= s1_last_q;
    s2_face_q <= s1_face_q;
    s2_code_q <= s1_code_q;
    for (int a = 0; a < 3; a++) begin
      s2_prod_q[a] <= CoordW'(s1_idx[a] * num_q[a]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: offset by the half extent and select, into the output register
  // --------------------------------------------------------------------------
  function automatic logic [CoordW-1:0] pick(input coord_sel_e sel,
                                             input logic [SizeW-1:0] size,
                                             input logic [SizeW-1:0] step,
                                             input logic [CoordW-1:0] prod);
    logic [CoordW-1:0] half;
    logic [CoordW-1:0] lo;
    half = CoordW'(size >> 1);
    lo   = prod - half;
    case (sel)
      CoordLo:  return lo;
      CoordHi:  return lo + CoordW'(step);
      CoordPos: return half;
      default:  return -half;
    endcase
  endfunction

  logic [CoordW-1:0] s2_coord [3];
  coord_sel_e        s2_sel [3];

  assign s2_sel[0] = s2_code_q.cx;
  assign s2_sel[1] = s2_code_q.cy;
  assign s2_sel[2] = s2_code_q.cz;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s2_coord[a] = s2_bad_q ? '0 : pick(s2_sel[a], size_q[a], num_q[a], s2_prod_q[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_valid_o <= 1'b0;
    end else begin
      vert_valid_o <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vert_o.vert_x   <= s2_coord[0];
    vert_o.vert_y   <= s2_coord[1];
    vert_o.vert_z   <= s2_coord[2];
    vert_o.face_id  <= s2_bad_q ? 3'd0 : s2_face_q;
    vert_o.bad_cell <= s2_bad_q;
    vert_o.last     <= s2_last_q;
  end

`ifndef SYNTHESIS
  // a bad cell is a single zeroed result that closes the cell
  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vert_valid_o && vert_o.bad_cell |-> vert_o.last && vert_o.vert_x == '0 &&
      vert_o.face_id == 3'd0)
    else $error("bad cell result malformed");

  // a good cell keeps the sequencer running until its last vertex
  a_seq_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_active_q && !seq_last |=> seq_active_q)
    else $error("sequencer dropped a cell early");

  // no cell is taken while the steps are being recomputed
  a_no_take_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> !cmd_fire)
    else $error("cell accepted during step division");
`endif

endmodule

// File: sim/bcvg_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcvg_checker
// Watches the command, configuration and vertex channels of the box cell
// vertex generator, predicts the vertices of every accepted cell and
// compares each strobed vertex with the oldest prediction.
// ----------------------------------------------------------------------------
module bcvg_checker
  import bcvg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  cell_t                cell_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDatW-1:0]   cfg_data_i,
  input  logic                 vert_valid_o,
  input  vert_t                vert_o,
  output int                   fail_count_o,
  output int                   pending_o
);

  logic [SizeW-1:0] box_x, box_y, box_z;
  logic [DivW-1:0]  grid_div;
  vert_t            vert_q[$];

  typedef enum logic [1:0] {SelLo, SelHi, SelPos, SelNeg} axis_sel_e;

  // Corner table, faces front, back, right, left, top, bottom; x, y, z per vertex.
  axis_sel_e corner_tbl [36][3];

  initial begin
    axis_sel_e L, H, P, N;
    L = SelLo; H = SelHi; P = SelPos; N = SelNeg;
    corner_tbl = '{
      '{L,L,P},'{H,L,P},'{L,H,P},'{L,H,P},'{H,L,P},'{H,H,P},
      '{L,L,N},'{L,H,N},'{H,L,N},'{L,H,N},'{H,H,N},'{H,L,N},
      '{P,L,L},'{P,H,L},'{P,L,H},'{P,H,L},'{P,H,H},'{P,L,H},
      '{N,L,L},'{N,L,H},'{N,H,L},'{N,H,L},'{N,L,H},'{N,H,H},
      '{L,P,L},'{L,P,H},'{H,P,L},'{L,P,H},'{H,P,H},'{H,P,L},
      '{L,N,L},'{H,N,L},'{L,N,H},'{L,N,H},'{H,N,L},'{H,N,H}};
  end

  function automatic logic [31:0] corner_coord(axis_sel_e sel, longint half,
                                               longint stride, longint idx);
    longint v;
    case (sel)
      SelLo:   v = -half + idx * stride;
      SelHi:   v = -half + stride + idx * stride;
      SelPos:  v = half;
      default: v = -half;
    endcase
    return v[31:0];
  endfunction

  // Append the vertices one cell produces under the current register set.
  task automatic push_cell_vertices(cell_t c);
    longint sx, sy, sz, hx, hy, hz, zi;
    vert_t  v;
    if (grid_div == 0 || grid_div > DefMaxDivisions ||
        c.cell_row >= grid_div || c.cell_col >= grid_div) begin
      v = '0;
      v.bad_cell = 1'b1;
      v.last     = 1'b1;
      vert_q = {vert_q, v};
    end else begin
      sx = box_x / grid_div; sy = box_y / grid_div; sz = box_z / grid_div;
      hx = box_x >> 1;       hy = box_y >> 1;       hz = box_z >> 1;
      for (int k = 0; k < 36; k++) begin
        zi = (k / 6 >= 4) ? c.cell_row : c.cell_col;
        v.vert_x   = corner_coord(corner_tbl[k][0], hx, sx, c.cell_col);
        v.vert_y   = corner_coord(corner_tbl[k][1], hy, sy, c.cell_row);
        v.vert_z   = corner_coord(corner_tbl[k][2], hz, sz, zi);
        v.face_id  = 3'(k / 6);
        v.bad_cell = 1'b0;
        v.last     = (k == 35);
        vert_q = {vert_q, v};
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vert_t exp_v;
    if (!rst_ni) begin
      box_x = 31'h1_0000; box_y = 31'h1_0000; box_z = 31'h1_0000;
      grid_div = 11'd1;
      vert_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (vert_valid_o) begin
        if (vert_q.size() == 0) begin
          $display("%0t: unexpected vertex, expected none, actual %h", $time, vert_o);
          fail_count_o++;
        end else begin
          exp_v = vert_q.pop_front();
          if (vert_o !== exp_v) begin
            $display("%0t: vertex mismatch, expected x=%h y=%h z=%h f=%0d b=%b l=%b,",
                     $time, exp_v.vert_x, exp_v.vert_y, exp_v.vert_z,
                     exp_v.face_id, exp_v.bad_cell, exp_v.last);
            $display("%0t:   actual x=%h y=%h z=%h f=%0d b=%b l=%b", $time,
                     vert_o.vert_x, vert_o.vert_y, vert_o.vert_z,
                     vert_o.face_id, vert_o.bad_cell, vert_o.last);
            fail_count_o++;
          end
        end
      end
      if (start && !busy) push_cell_vertices(cell_i);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgSizeX:     box_x = cfg_data_i[SizeW-1:0];
          CfgSizeY:     box_y = cfg_data_i[SizeW-1:0];
          CfgSizeZ:     box_z = cfg_data_i[SizeW-1:0];
          CfgDivisions: grid_div = cfg_data_i[DivW-1:0];
          default: ;
        endcase
      end
      pending_o = vert_q.size();
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives cells and register writes into the box cell vertex generator
// under several idle patterns; the checker predicts and compares vertices.
// ----------------------------------------------------------------------------
module testbench;
  import bcvg_pkg::*;

  localparam int CycleLimit = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  cell_t               cell_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDatW-1:0]  cfg_data_i = '0;
  logic                vert_valid_o;
  vert_t               vert_o;
  int                  fail_count, pending;
  int                  cycles = 0;
  int                  idle_pct = 0;
  int unsigned         cur_div = 1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  box_cell_vertex_generator dut (
    .clk_i, .rst_ni, .start, .busy, .cell_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .vert_valid_o, .vert_o
  );

  bcvg_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .cell_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .vert_valid_o, .vert_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** box_cell_vertex_generator: FAILED **");
      $finish;
    end
  end

  // Offer one cell, idling first at random; hold start until the transfer.
  // Start stays high afterwards so the next cell can follow at once.
  task automatic send_cell(int unsigned row, int unsigned col);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    cell_i <= '{cell_row: row[IdxW-1:0], cell_col: col[IdxW-1:0]};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Drop start, let every vertex drain, then allow for the pipeline before
  // touching registers.
  task automatic drain();
    start <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Hold the write until it transfers; valid stays high for a following write.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgDivisions) cur_div = val[DivW-1:0];
  endtask

  // Sizes and divisions for one phase; wait out the step divider afterwards.
  task automatic set_box(int unsigned sx, int unsigned sy, int unsigned sz,
                         int unsigned div);
    drain();
    write_reg(CfgSizeX, sx);
    write_reg(CfgSizeY, sy);
    write_reg(CfgSizeZ, sz);
    write_reg(CfgDivisions, div);
    cfg_valid_i <= 1'b0;
    while (busy) @(posedge clk_i);
  endtask

  // Mostly cells inside the grid, the rest anywhere in the index range.
  task automatic random_cells(int n);
    int unsigned r, c, lim;
    lim = (cur_div == 0) ? 0 : cur_div - 1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8 && cur_div != 0 && cur_div <= DefMaxDivisions) begin
        r = $urandom_range(lim);
        c = $urandom_range(lim);
      end else begin
        r = $urandom_range(1023);
        c = $urandom_range(1023);
      end
      send_cell(r, c);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: single cell, its out-of-grid neighbours, the far corner.
    send_cell(0, 0);
    send_cell(1, 0);
    send_cell(0, 1);
    send_cell(1023, 1023);

    // Largest box, largest grid: the corner cells and the extremes.
    set_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1024);
    send_cell(0, 0);
    send_cell(1023, 1023);
    send_cell(0, 1023);
    send_cell(1023, 0);
    send_cell(682, 341);

    // Zero sizes, zero divisions (every cell bad), too many divisions.
    set_box(0, 0, 0, 3);
    send_cell(2, 1);
    send_cell(3, 0);
    set_box(32'hFFFF_FFFF, 12345, 1, 0);
    send_cell(0, 0);
    send_cell(5, 9);
    set_box(65536, 65536, 65536, 1025);
    send_cell(0, 0);
    set_box(65536, 65536, 65536, 2047);
    send_cell(0, 0);
    drain();
    // Unknown register index must be ignored.
    write_reg(8'hFF, 32'h0);
    write_reg(8'd4, 32'h5);
    cfg_valid_i <= 1'b0;

    // Random phases, each with its own register set and one of three idle patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 82;
        2: idle_pct = 22;
        default: idle_pct = 0;
      endcase
      set_box($urandom, $urandom, $urandom,
              (ph == 7) ? 1024 : $urandom_range(1, 40));
      random_cells(28);
      // Hold off once until the block has emptied.
      if (ph == 3) drain();
      random_cells(6);
    end
    idle_pct = 0;

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** box_cell_vertex_generator: PASSED **");
    end else begin
      $display("** box_cell_vertex_generator: FAILED **");
    end
    $finish;
  end

endmodule
